/* src/xbau_pkg.sv */
// ----------------------------------------------------------------------------
// xbau_pkg
// Shared types, constants and helpers of the x86 branch address unfilter.
// ----------------------------------------------------------------------------
package xbau_pkg;

    localparam int WINDOW_BYTES = 6;

    // Lookahead window, byte 0 is the head.
    typedef logic [WINDOW_BYTES-1:0][7:0] win_t;

    localparam logic [7:0] CALL_OP     = 8'hE8;
    localparam logic [7:0] JMP_OP      = 8'hE9;
    localparam logic [7:0] IND_OP0     = 8'hFF;
    localparam logic [7:0] IND_OP1     = 8'h25;
    localparam logic [7:0] JCC_ESC     = 8'h0F;
    localparam logic [3:0] JCC_HI      = 4'h8;
    localparam logic [31:0] UPPER_MASK = 32'hFFFF0000;
    localparam logic [31:0] ACC_STEP   = 32'd4;

    localparam logic [2:0] SKIP_CALL    = 3'd4;
    localparam logic [2:0] SKIP_JCC     = 3'd5;
    localparam logic [2:0] SKIP_IND_ADD = 3'd7;
    localparam logic [2:0] SKIP_IND_SUB = 3'd5;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_IND_SUB    = 3'd0;
    localparam logic [2:0] REG_JCC_SWAP   = 3'd1;
    localparam logic [2:0] REG_JCC_MARKER = 3'd2;
    localparam logic [2:0] REG_CALL_SWAP  = 3'd3;
    localparam logic [2:0] REG_CALL_MARK  = 3'd4;
    localparam logic [2:0] REG_CALL_OFF   = 3'd5;

    typedef struct packed {
        logic       indirect_subtract_mode;
        logic       jcc_swap_enable;
        logic [7:0] jcc_marker;
        logic       call_swap_enable;
        logic [7:0] call_marker;
        logic       call_plain_disable;
    } cfg_t;

    typedef struct packed {
        win_t        win;
        logic [2:0]  skip;
        logic [31:0] acc;
    } exam_t;

    // Keep the upper half of the dword, then swap its two bytes down.
    function automatic logic [31:0] mask_swap(input logic [31:0] v);
        logic [31:0] m;
        m = v & UPPER_MASK;
        return {16'h0000, m[23:16], m[31:24]};
    endfunction

endpackage

/* src/xbau_examine.sv */
// ----------------------------------------------------------------------------
// xbau_examine
// Head examination of a full window: decodes the branch form at the head
// and restores its displacement with one shared 32-bit adder.
// ----------------------------------------------------------------------------
module xbau_examine
    import xbau_pkg::*;
(
    input  win_t        win,
    input  cfg_t        cfg,
    input  logic [31:0] position,
    input  logic [31:0] acc,
    input  logic [2:0]  skip,
    output exam_t       result
);

    logic [31:0] d1;
    logic [31:0] d2;
    logic        is_call;
    logic        is_ind;
    logic        is_jcc;
    logic [31:0] opa;
    logic [31:0] opb;
    logic        sub;
    logic        wr1;
    logic        wr2;
    logic [31:0] sum;
    logic [2:0]  skip_out;
    logic [31:0] acc_out;
    win_t        win_out;

    assign d1 = win[4:1];
    assign d2 = win[5:2];

    assign is_call = (win[0] == CALL_OP) || (win[0] == JMP_OP);
    assign is_ind  = (win[0] == IND_OP0) && (win[1] == IND_OP1);
    assign is_jcc  = (win[0] == JCC_ESC) && (win[1][7:4] == JCC_HI);

    always_comb
    begin
        opa      = d1;
        opb      = position;
        sub      = 1'b1;
        wr1      = 1'b0;
        wr2      = 1'b0;
        skip_out = skip;
        acc_out  = acc;
        if (skip != 3'd0)
        begin
            skip_out = skip - 3'd1;
        end
        else if (is_call)
        begin
            if (cfg.call_swap_enable && (win[1] == cfg.call_marker))
            begin
                opa      = mask_swap(d1);
                wr1      = 1'b1;
                skip_out = SKIP_CALL;
            end
            else if (!cfg.call_plain_disable)
            begin
                wr1      = !cfg.call_swap_enable;
                skip_out = SKIP_CALL;
            end
        end
        else if (is_ind)
        begin
            opa      = d2;
            opb      = acc;
            sub      = cfg.indirect_subtract_mode;
            wr2      = 1'b1;
            skip_out = cfg.indirect_subtract_mode ? SKIP_IND_SUB : SKIP_IND_ADD;
            acc_out  = acc - ACC_STEP;
        end
        else if (is_jcc)
        begin
            opa      = (cfg.jcc_swap_enable && (win[2] == cfg.jcc_marker)) ?
                       mask_swap(d2) : d2;
            wr2      = 1'b1;
            skip_out = SKIP_JCC;
        end
    end

    assign sum = sub ? (opa - opb) : (opa + opb);

    always_comb
    begin
        win_out = win;
        if (wr1)
        begin
            win_out[4:1] = sum;
        end
        if (wr2)
        begin
            win_out[5:2] = sum;
        end
    end

    assign result = {win_out, skip_out, acc_out};

endmodule

/* src/x86_branch_address_unfilter_unit.sv */
// ----------------------------------------------------------------------------
// x86_branch_address_unfilter_unit
// Undoes an x86 branch filter on a byte stream, one byte per request.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock and gives one restored byte per clock
// while the output is not stalled, once its five-byte lookahead is loaded;
// the head of the six-byte window is examined and rewritten in the cycle its
// sixth byte arrives, through one 32-bit adder, and lands in the output
// register. At the end of a region (in_last) the held bytes are drained one
// per clock while the output is not stalled; the input stalls until the
// drain is done. A region shorter than six bytes comes out unchanged with
// out_too_short set on its last byte. Configuration must be written over
// the APB port only while the unit is idle; the unit does not enforce it.
module x86_branch_address_unfilter_unit
    import xbau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_too_short
);

    localparam int          HOLD     = WINDOW_BYTES - 1;
    localparam logic [2:0]  FILL_MAX = 3'(HOLD);

    cfg_t        cfg_reg;
    logic [2:0]  reg_sel;

    logic [7:0]  wnd_reg  [HOLD];
    logic [7:0]  wnd_next [HOLD];
    logic [2:0]  fill_reg, fill_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  skip_reg, skip_next;
    logic        flush_reg, flush_next;
    logic        short_reg, short_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic        out_short_reg, out_short_next;

    win_t        full_win;
    exam_t       ex;
    logic        adv;
    logic        in_acc;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                REG_IND_SUB:    cfg_reg.indirect_subtract_mode <= pwdata[0];
                REG_JCC_SWAP:   cfg_reg.jcc_swap_enable        <= pwdata[0];
                REG_JCC_MARKER: cfg_reg.jcc_marker             <= pwdata[7:0];
                REG_CALL_SWAP:  cfg_reg.call_swap_enable       <= pwdata[0];
                REG_CALL_MARK:  cfg_reg.call_marker            <= pwdata[7:0];
                REG_CALL_OFF:   cfg_reg.call_plain_disable     <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_IND_SUB:    prdata = {31'd0, cfg_reg.indirect_subtract_mode};
            REG_JCC_SWAP:   prdata = {31'd0, cfg_reg.jcc_swap_enable};
            REG_JCC_MARKER: prdata = {24'd0, cfg_reg.jcc_marker};
            REG_CALL_SWAP:  prdata = {31'd0, cfg_reg.call_swap_enable};
            REG_CALL_MARK:  prdata = {24'd0, cfg_reg.call_marker};
            REG_CALL_OFF:   prdata = {31'd0, cfg_reg.call_plain_disable};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Window and head examination
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < HOLD; i++)
        begin
            full_win[i] = wnd_reg[i];
        end
        full_win[HOLD] = in_byte;
    end

    xbau_examine u_examine (
        .win      (full_win),
        .cfg      (cfg_reg),
        .position (pos_reg),
        .acc      (acc_reg),
        .skip     (skip_reg),
        .result   (ex)
    );

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = flush_reg || ((fill_reg == FILL_MAX) && !adv);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        wnd_next       = wnd_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        skip_next      = skip_reg;
        flush_next     = flush_reg;
        short_next     = short_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_short_next = out_short_reg;

        if (adv)
        begin
            out_valid_next = 1'b0;
        end

        if (flush_reg)
        begin
            // Drain the held bytes, the oldest first.
            if (adv)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = wnd_reg[0];
                out_last_next  = (fill_reg == 3'd1);
                out_short_next = (fill_reg == 3'd1) && short_reg;
                for (int i = 0; i < HOLD - 1; i++)
                begin
                    wnd_next[i] = wnd_reg[i+1];
                end
                fill_next = fill_reg - 3'd1;
                if (fill_reg == 3'd1)
                begin
                    flush_next = 1'b0;
                end
            end
        end
        else if (in_acc)
        begin
            if (fill_reg == FILL_MAX)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = full_win[0];
                out_last_next  = 1'b0;
                out_short_next = 1'b0;
                for (int i = 0; i < HOLD; i++)
                begin
                    wnd_next[i] = ex.win[i+1];
                end
                skip_next  = ex.skip;
                acc_next   = ex.acc;
                pos_next   = pos_reg + 32'd1;
                short_next = 1'b0;
            end
            else
            begin
                wnd_next[fill_reg] = in_byte;
                fill_next          = fill_reg + 3'd1;
                short_next         = 1'b1;
            end

            if (in_last)
            begin
                flush_next = 1'b1;
                pos_next   = '0;
                acc_next   = '0;
                skip_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            skip_reg      <= '0;
            flush_reg     <= 1'b0;
            short_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            skip_reg      <= skip_next;
            flush_reg     <= flush_next;
            short_reg     <= short_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wnd_reg       <= wnd_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_short_reg <= out_short_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_last      = out_last_reg;
    assign out_too_short = out_short_reg;

endmodule

/* src/xbau_checker.sv */
// ----------------------------------------------------------------------------
// xbau_checker
// Port-level checks of the branch address unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module xbau_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic       out_too_short
);

    // The end of a region always starts a drain of held bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_last |=> in_stall)
    else $error("region end did not block the next request");

    // The short-region flag only rides on the final byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_too_short |-> out_last)
    else $error("too_short seen on a byte that is not the last");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled result request changed or vanished");

endmodule

bind x86_branch_address_unfilter_unit xbau_checker u_xbau_checker (.*);
